>>> design/imu_frame_sync_checksum_top_macros.svh
// Assertion macros shared by the frame sync checksum modules.
`ifndef IMU_FRAME_SYNC_CHECKSUM_TOP_MACROS_SVH
`define IMU_FRAME_SYNC_CHECKSUM_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define IFSC_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("ifsc assertion failed");
`define IFSC_ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("ifsc assertion failed");
`else
`define IFSC_ASSERT_IMP(lbl, clk, rst, a, c)
`define IFSC_ASSERT_NEXT(lbl, clk, rst, a, c)
`endif
`endif

>>> design/ifsc_pkg.sv
// Types and constants shared by the frame sync checksum modules.
package ifsc_pkg;

  localparam int FRAME_LEN = 11;
  localparam logic [3:0] LAST_IDX = 4'd10;
  localparam logic [3:0] SUM_LAST = 4'd9;
  localparam logic [7:0] SYNC_RESET = 8'h55;
  localparam logic REG_SYNC = 1'b0;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_GOOD = 2'd1,
    EV_BAD  = 2'd2
  } ev_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_CHECK,
    ST_SHIFT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic take;
    logic sum_step;
    logic check;
    logic shift;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic store;
    logic last_byte;
    logic sum_last;
    logic frame_ok;
    logic shift_more;
    logic out_free;
  } stat_t;

endpackage

>>> design/ifsc_ctrl.sv
// Controller state machine that sequences store, checksum, resync and result transfer.
module ifsc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ifsc_pkg::stat_t stat,
  output ifsc_pkg::cmd_t  cmd
);
  import ifsc_pkg::*;

  `include "imu_frame_sync_checksum_top_macros.svh"

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (stat.store && stat.last_byte) ? ST_SUM : ST_EMIT;
        end
      end
      ST_SUM: begin
        if (stat.sum_last) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = stat.frame_ok ? ST_EMIT : ST_SHIFT;
      end
      ST_SHIFT: begin
        if (!stat.shift_more) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_SUM:   cmd.sum_step = 1'b1;
      ST_CHECK: cmd.check = 1'b1;
      ST_SHIFT: cmd.shift = stat.shift_more;
      ST_EMIT:  cmd.emit = stat.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

  `IFSC_ASSERT_NEXT(a_take_leaves_idle, clk, rst, cmd.take, state != ST_IDLE)
  `IFSC_ASSERT_NEXT(a_emit_returns_idle, clk, rst, cmd.emit, state == ST_IDLE)
  `IFSC_ASSERT_IMP(a_one_command, clk, rst, 1'b1, $onehot0(cmd))

endmodule

>>> design/ifsc_datapath.sv
// Datapath: frame window, serial checksum, counters and result register.
module ifsc_datapath #(
  parameter int COUNT_BITS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      rx_byte,
  input  logic [7:0]      sync_byte,
  input  ifsc_pkg::cmd_t  cmd,
  output ifsc_pkg::stat_t stat,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [167:0]    out_data,
  output logic [1:0]      out_user
);
  import ifsc_pkg::*;

  `include "imu_frame_sync_checksum_top_macros.svh"

  logic [7:0]            win [FRAME_LEN];
  logic [3:0]            fill;
  logic [3:0]            idx;
  logic [7:0]            sum;
  ev_t                   ev;
  logic [COUNT_BITS-1:0] byte_cnt;
  logic [COUNT_BITS-1:0] good_cnt;
  logic [COUNT_BITS-1:0] bad_cnt;
  logic                  shift_en;
  logic                  is_good;
  logic [167:0]          payload;

  assign stat.store      = (fill != 4'd0) || (rx_byte == sync_byte);
  assign stat.last_byte  = (fill == LAST_IDX);
  assign stat.sum_last   = (idx == SUM_LAST);
  assign stat.frame_ok   = (win[0] == sync_byte) && (sum == win[LAST_IDX]);
  assign stat.shift_more = (fill != 4'd0) && (win[0] != sync_byte);
  assign stat.out_free   = !out_valid || out_ready;

  assign shift_en = (cmd.check && !stat.frame_ok) || cmd.shift;

  always_ff @(posedge clk) begin
    if (cmd.take && stat.store) begin
      win[fill] <= rx_byte;
    end else if (shift_en) begin
      for (int i = 0; i < FRAME_LEN - 1; i++) begin
        win[i] <= win[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      idx <= 4'd0;
      sum <= 8'd0;
    end else if (cmd.sum_step) begin
      idx <= idx + 4'd1;
      sum <= sum + win[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= 4'd0;
      ev       <= EV_NONE;
      byte_cnt <= '0;
      good_cnt <= '0;
      bad_cnt  <= '0;
    end else begin
      if (cmd.take) begin
        byte_cnt <= byte_cnt + COUNT_BITS'(1);
        ev       <= EV_NONE;
        if (stat.store) begin
          fill <= fill + 4'd1;
        end
      end else if (cmd.check) begin
        if (stat.frame_ok) begin
          ev       <= EV_GOOD;
          fill     <= 4'd0;
          good_cnt <= good_cnt + COUNT_BITS'(1);
        end else begin
          ev      <= EV_BAD;
          fill    <= fill - 4'd1;
          bad_cnt <= bad_cnt + COUNT_BITS'(1);
        end
      end else if (cmd.shift) begin
        fill <= fill - 4'd1;
      end
    end
  end

  assign is_good = (ev == EV_GOOD);

  always_comb begin
    payload = '0;
    if (is_good) begin
      payload[7:0]   = win[1];
      payload[23:8]  = {win[3], win[2]};
      payload[39:24] = {win[5], win[4]};
      payload[55:40] = {win[7], win[6]};
      payload[71:56] = {win[9], win[8]};
    end
    payload[103:72]  = 32'(byte_cnt);
    payload[135:104] = 32'(good_cnt);
    payload[167:136] = 32'(bad_cnt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= payload;
      out_user <= ev;
    end
  end

  `IFSC_ASSERT_IMP(a_fill_in_range, clk, rst, 1'b1, fill <= LAST_IDX + 4'd1)
  `IFSC_ASSERT_NEXT(a_bad_counts, clk, rst, cmd.check && !stat.frame_ok,
                    bad_cnt == $past(bad_cnt) + COUNT_BITS'(1))
  `IFSC_ASSERT_IMP(a_check_full, clk, rst, cmd.check, fill == LAST_IDX + 4'd1)

endmodule

>>> design/imu_frame_sync_checksum_top.sv
// Top level: 11-byte sensor frame sync and checksum with APB register and result stream.
// Each received byte is one input transfer; each byte gives exactly one result transfer
// whose tuser says whether a frame finished (0 none, 1 good, 2 rejected). A byte that does
// not complete a window is stored or dropped, then its result is sent. A byte that
// completes the 11-byte window is summed and checked; a good frame then gives its result.
// A rejected frame is shifted by one byte at the check and then resynced, dropping bytes
// until the window is empty or starts with the sync byte, before its result is sent. The
// checksum adder takes one window byte per cycle, and the resync moves the window one
// position per cycle. A result that waits in the output register stalls the next result,
// not the next input transfer. The counters are COUNT_BITS wide and wrap; the result
// carries their low 32 bits. The sync byte register lies at address 0 and resets to 0x55;
// write it only while no byte is in flight.
module imu_frame_sync_checksum_top #(
  parameter int COUNT_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // rx_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  // frame_type[7:0], value_x[23:8], value_y[39:24], value_z[55:40],
  // value_extra[71:56], bytes_seen[103:72], frames_good[135:104], frames_bad[167:136]
  output logic [167:0] m_tdata,
  output logic [1:0]   m_tuser    // event_res
);
  import ifsc_pkg::*;

  logic [7:0] sync_byte;
  logic       reg_idx;
  cmd_t       cmd;
  stat_t      stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte <= SYNC_RESET;
    end else if (psel && penable && pwrite && pready && (reg_idx == REG_SYNC)) begin
      sync_byte <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (reg_idx == REG_SYNC) begin
      prdata = {24'd0, sync_byte};
    end
  end

  ifsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ifsc_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .rx_byte   (s_tdata),
    .sync_byte (sync_byte),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_user  (m_tuser)
  );

endmodule

>>> sim/tb_imu_frame_sync_checksum_top.sv
// Testbench for the frame sync checksum block: byte stream in, one checked result per byte.
module tb_imu_frame_sync_checksum_top;
  import ifsc_pkg::*;

  typedef struct packed {
    ev_t                ev;
    logic [7:0]         frame_type;
    logic signed [15:0] value_x;
    logic signed [15:0] value_y;
    logic signed [15:0] value_z;
    logic signed [15:0] value_extra;
    logic [31:0]        bytes_seen;
    logic [31:0]        frames_good;
    logic [31:0]        frames_bad;
  } frame_result_t;

  localparam logic [2:0] SYNC_ADDR = {REG_SYNC, 2'b00};

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = '0;   // rx_byte
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // frame_type[7:0], value_x[23:8], value_y[39:24], value_z[55:40],
  // value_extra[71:56], bytes_seen[103:72], frames_good[135:104], frames_bad[167:136]
  logic [167:0] m_tdata;
  logic [1:0]   m_tuser;        // event_res

  logic [7:0]    sync_reg = SYNC_RESET;
  logic [7:0]    win [FRAME_LEN];
  int unsigned   win_fill = 0;
  logic [31:0]   cnt_bytes = '0;
  logic [31:0]   cnt_good = '0;
  logic [31:0]   cnt_bad = '0;
  frame_result_t frame_results_due [$];
  frame_result_t got_res;
  frame_result_t want_res;
  int            mismatches = 0;
  bit            steady = 1'b0;

  imu_frame_sync_checksum_top dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= 22);
  end

  function automatic logic [7:0] header_sum(input logic [7:0] fr [FRAME_LEN]);
    logic [7:0] sum;
    sum = '0;
    for (int i = 0; i < FRAME_LEN - 1; i++) sum += fr[i];
    return sum;
  endfunction

  task automatic drop_head();
    for (int i = 0; i < FRAME_LEN - 1; i++) win[i] = win[i + 1];
    if (win_fill > 0) win_fill--;
  endtask

  task automatic track_rx_byte(input logic [7:0] rx);
    frame_result_t r;
    r = '0;
    r.ev = EV_NONE;
    cnt_bytes++;
    if (win_fill >= FRAME_LEN) win_fill = 0;
    if (!(win_fill == 0 && rx != sync_reg)) begin
      win[win_fill] = rx;
      win_fill++;
      if (win_fill == FRAME_LEN) begin
        if (win[0] == sync_reg && header_sum(win) == win[FRAME_LEN - 1]) begin
          r.ev = EV_GOOD;
          r.frame_type = win[1];
          r.value_x = {win[3], win[2]};
          r.value_y = {win[5], win[4]};
          r.value_z = {win[7], win[6]};
          r.value_extra = {win[9], win[8]};
          win_fill = 0;
          cnt_good++;
        end else begin
          r.ev = EV_BAD;
          cnt_bad++;
          drop_head();
          while (win_fill > 0 && win[0] != sync_reg) drop_head();
        end
      end
    end
    r.bytes_seen = cnt_bytes;
    r.frames_good = cnt_good;
    r.frames_bad = cnt_bad;
    frame_results_due.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    if (mismatches < 10)
      $display("mismatch %s: expected %h got %h at %0t", what, want, got, $time);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_res.ev = ev_t'(m_tuser);
      got_res.frame_type = m_tdata[7:0];
      got_res.value_x = m_tdata[23:8];
      got_res.value_y = m_tdata[39:24];
      got_res.value_z = m_tdata[55:40];
      got_res.value_extra = m_tdata[71:56];
      got_res.bytes_seen = m_tdata[103:72];
      got_res.frames_good = m_tdata[135:104];
      got_res.frames_bad = m_tdata[167:136];
      if (frame_results_due.size() == 0) begin
        report_mismatch("unexpected transfer", '0, got_res.bytes_seen);
      end else begin
        want_res = frame_results_due.pop_front();
        if (got_res.ev !== want_res.ev)
          report_mismatch("event_res", 32'(want_res.ev), 32'(got_res.ev));
        if (got_res.frame_type !== want_res.frame_type)
          report_mismatch("frame_type", 32'(want_res.frame_type), 32'(got_res.frame_type));
        if (got_res.value_x !== want_res.value_x)
          report_mismatch("value_x", 32'(want_res.value_x), 32'(got_res.value_x));
        if (got_res.value_y !== want_res.value_y)
          report_mismatch("value_y", 32'(want_res.value_y), 32'(got_res.value_y));
        if (got_res.value_z !== want_res.value_z)
          report_mismatch("value_z", 32'(want_res.value_z), 32'(got_res.value_z));
        if (got_res.value_extra !== want_res.value_extra)
          report_mismatch("value_extra", 32'(want_res.value_extra),
                          32'(got_res.value_extra));
        if (got_res.bytes_seen !== want_res.bytes_seen)
          report_mismatch("bytes_seen", want_res.bytes_seen, got_res.bytes_seen);
        if (got_res.frames_good !== want_res.frames_good)
          report_mismatch("frames_good", want_res.frames_good, got_res.frames_good);
        if (got_res.frames_bad !== want_res.frames_bad)
          report_mismatch("frames_bad", want_res.frames_bad, got_res.frames_bad);
      end
    end
  end

  task automatic send_byte(input logic [7:0] rx);
    s_tdata <= rx;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    track_rx_byte(rx);
    if (!steady && $urandom_range(99) < 22) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(24, 1)) @(posedge clk);
    end
  endtask

  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    while (frame_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_sync(input logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SYNC_ADDR;
    pwdata <= {24'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sync_reg = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_frame(input bit bad_sum, input int len);
    logic [7:0] fr [FRAME_LEN];
    fr[0] = sync_reg;
    for (int i = 1; i < FRAME_LEN - 1; i++) fr[i] = 8'($urandom_range(255));
    if (bad_sum && $urandom_range(1)) fr[$urandom_range(9, 2)] = sync_reg;
    fr[FRAME_LEN - 1] = header_sum(fr);
    if (bad_sum) fr[FRAME_LEN - 1] ^= 8'($urandom_range(255, 1));
    for (int i = 0; i < len; i++) send_byte(fr[i]);
  endtask

  // noise, a good frame at the value extremes, then a bad frame holding a second header
  task automatic test_reset_sync_frames();
    logic [7:0] fr [FRAME_LEN];
    send_byte(8'h00);
    send_byte(8'hFF);
    fr = '{SYNC_RESET, 8'hFF, 8'hFF, 8'h7F, 8'h00, 8'h80, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00};
    fr[FRAME_LEN - 1] = header_sum(fr);
    foreach (fr[i]) send_byte(fr[i]);
    fr = '{SYNC_RESET, 8'h01, 8'h02, 8'h03, 8'h04, SYNC_RESET, 8'h06, 8'h07, 8'h08, 8'h09,
           8'h00};
    fr[FRAME_LEN - 1] = header_sum(fr) ^ 8'h01;
    foreach (fr[i]) send_byte(fr[i]);
  endtask

  // change the header while the window holds a partial frame
  task automatic test_sync_change_midframe();
    logic [7:0] sum;
    logic [7:0] rx;
    wait_results_drained();
    write_sync(8'hA5);
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(8'hA5);
    send_byte(8'h33);
    send_byte(8'h44);
    sum = 8'hA5 + 8'h33 + 8'h44;
    for (int i = 0; i < 7; i++) begin
      rx = 8'($urandom_range(255));
      sum += rx;
      send_byte(rx);
    end
    send_byte(sum);
  endtask

  task automatic test_random_traffic();
    logic [7:0] phase_sync [4];
    int sent;
    int pick;
    int len;
    phase_sync = '{8'h00, 8'hFF, 8'($urandom_range(255)), SYNC_RESET};
    for (int p = 0; p < 4; p++) begin
      wait_results_drained();
      write_sync(phase_sync[p]);
      steady = (p == 2);
      sent = 0;
      while (sent < 200) begin
        pick = $urandom_range(99);
        if (pick < 65) begin
          send_frame(1'b0, FRAME_LEN);
          sent += FRAME_LEN;
        end else if (pick < 78) begin
          send_frame(1'b1, FRAME_LEN);
          sent += FRAME_LEN;
        end else if (pick < 88) begin
          len = $urandom_range(FRAME_LEN - 2, 2);
          send_frame(1'b0, len);
          sent += len;
        end else begin
          len = $urandom_range(4, 1);
          repeat (len) send_byte(8'($urandom_range(255)));
          sent += len;
        end
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_sync_frames();
    test_sync_change_midframe();
    test_random_traffic();
    wait_results_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("[imu_frame_sync_checksum_top] OK");
    end else begin
      $display("[imu_frame_sync_checksum_top] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[imu_frame_sync_checksum_top] ERROR");
    $finish;
  end

endmodule
